### design/keypad_combination_lock_core_assert.svh
// ----------------------------------------------------------------------------
// Keypad combination lock assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_COMBINATION_LOCK_CORE_ASSERT_SVH
`define KEYPAD_COMBINATION_LOCK_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every edge outside reset
`define KCLOCK_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Trigger in one cycle implies consequence in the next
`define KCLOCK_ASSERT_NEXT(label, clk, rstn, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cons)) \
        else $error(msg);

`else

`define KCLOCK_ASSERT(label, clk, rstn, prop, msg)
`define KCLOCK_ASSERT_NEXT(label, clk, rstn, trig, cons, msg)

`endif

`endif

### design/kclock_pkg.sv
// ----------------------------------------------------------------------------
// Keypad combination lock package
// Shared sizes, key codes, event codes and mode type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kclock_pkg;

    // Number of digits in a code
    localparam int CODE_DIGITS = 8;
    // Buffer index and digit counter widths (counter at least 4 bits wide)
    localparam int IDX_W   = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
    localparam int COUNT_W = ($clog2(CODE_DIGITS + 1) > 4) ? $clog2(CODE_DIGITS + 1) : 4;

    typedef logic [3:0] digit_t;
    typedef digit_t [CODE_DIGITS-1:0] digit_buf_t;

    // Key codes
    localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;   // key for digit 0
    localparam logic [3:0] KEY_CONFIRM    = 4'd10;
    localparam logic [3:0] KEY_CLEAR      = 4'd11;
    localparam logic [3:0] KEY_CLOSE      = 4'd12;
    localparam logic [3:0] KEY_MANUAL     = 4'd13;

    // Configuration register indexes
    localparam logic REG_CODE_WORD    = 1'b0;
    localparam logic REG_MAX_ATTEMPTS = 1'b1;

    // Reset values of the configuration registers
    localparam logic [31:0] CODE_WORD_RESET    = 32'h8644_5131;
    localparam logic [3:0]  MAX_ATTEMPTS_RESET = 4'd3;

    typedef enum logic [1:0] {
        MODE_ENTRY   = 2'd0,
        MODE_GRANTED = 2'd1,
        MODE_MANUAL  = 2'd2
    } lock_mode_t;

    typedef enum logic [2:0] {
        EV_IGNORED = 3'd0,
        EV_DIGIT   = 3'd1,
        EV_GRANTED = 3'd2,
        EV_WRONG   = 3'd3,
        EV_ALARM   = 3'd4,
        EV_CLEARED = 3'd5,
        EV_CLOSED  = 3'd6,
        EV_MANUAL  = 3'd7
    } event_t;

    typedef enum logic [1:0] {
        DRIVE_NONE  = 2'd0,
        DRIVE_OPEN  = 2'd1,
        DRIVE_CLOSE = 2'd2
    } drive_t;

endpackage

### design/keypad_combination_lock_core.sv
// ----------------------------------------------------------------------------
// Keypad combination lock core
// Takes one decoded key press per item and returns one lock event per item.
//
//   channel | direction | ports                                  | handshake
//   --------+-----------+----------------------------------------+-----------
//   key     | in        | s_key_index                            | valid/ready
//   event   | out       | m_event_code, m_door_drive,            | valid/ready
//           |           | m_digits_entered, m_error_count,       |
//           |           | m_awaiting_close                       |
//   config  | in        | cfg_we, cfg_index, cfg_wdata           | write only
//
// One item per cycle: the lock state and the output register both load at the
// accepting edge.
// The limit is the single output register: s_ready is low only while a
// result is held and m_ready is low.
// Synchronous active-low reset restores the default code and limit, empties
// the entry and error counts and returns to entry mode. No clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "keypad_combination_lock_core_assert.svh"

module keypad_combination_lock_core (
    input  logic        aclk,
    input  logic        aresetn,
    // key channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_key_index,
    // event channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_code,
    output logic [1:0]  m_door_drive,
    output logic [3:0]  m_digits_entered,
    output logic [3:0]  m_error_count,
    output logic        m_awaiting_close,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int CW = kclock_pkg::COUNT_W;
    localparam int IW = kclock_pkg::IDX_W;

    logic [31:0] code_word_reg;
    logic [3:0]  max_attempts_reg;

    kclock_pkg::digit_buf_t digit_buf_reg;
    logic [CW-1:0]          digit_count_reg, digit_count_next;
    logic [3:0]             wrong_count_reg, wrong_count_next;
    kclock_pkg::lock_mode_t mode_reg, mode_next;

    logic                   m_valid_reg, m_valid_next;
    kclock_pkg::event_t     event_reg, event_next;
    kclock_pkg::drive_t     drive_reg, drive_next;
    logic [3:0]             digits_reg;
    logic [3:0]             errors_reg;
    logic                   awaiting_reg;

    logic                   accept;
    logic                   buf_we;
    kclock_pkg::digit_t     digit_value;
    logic                   code_match;
    logic [3:0]             wrong_inc;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_word_reg    <= kclock_pkg::CODE_WORD_RESET;
            max_attempts_reg <= kclock_pkg::MAX_ATTEMPTS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                kclock_pkg::REG_CODE_WORD:    code_word_reg    <= cfg_wdata;
                kclock_pkg::REG_MAX_ATTEMPTS: max_attempts_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    kclock_match u_match (
        .digit_buf  (digit_buf_reg),
        .code_word  (code_word_reg),
        .code_match (code_match)
    );

    // Key 9 stands for digit 0, keys 0..8 for digits 1..9
    assign digit_value = (s_key_index == kclock_pkg::KEY_LAST_DIGIT) ? 4'd0
                                                                     : s_key_index + 4'd1;
    // Error counter saturates at 15
    assign wrong_inc = (wrong_count_reg == 4'hF) ? wrong_count_reg : wrong_count_reg + 4'd1;

    // Next state and event for the key on the input
    always_comb begin
        digit_count_next = digit_count_reg;
        wrong_count_next = wrong_count_reg;
        mode_next        = mode_reg;
        event_next       = kclock_pkg::EV_IGNORED;
        drive_next       = kclock_pkg::DRIVE_NONE;
        buf_we           = 1'b0;
        case (mode_reg)
            kclock_pkg::MODE_GRANTED, kclock_pkg::MODE_MANUAL: begin
                // door open: only close is taken
                if (s_key_index == kclock_pkg::KEY_CLOSE) begin
                    event_next       = kclock_pkg::EV_CLOSED;
                    drive_next       = (mode_reg == kclock_pkg::MODE_GRANTED)
                                       ? kclock_pkg::DRIVE_CLOSE : kclock_pkg::DRIVE_NONE;
                    digit_count_next = '0;
                    wrong_count_next = '0;
                    mode_next        = kclock_pkg::MODE_ENTRY;
                end
            end
            default: begin
                mode_next = kclock_pkg::MODE_ENTRY;
                if (s_key_index <= kclock_pkg::KEY_LAST_DIGIT) begin
                    // digits beyond a full buffer are dropped
                    if (digit_count_reg < CW'(kclock_pkg::CODE_DIGITS)) begin
                        buf_we           = 1'b1;
                        digit_count_next = digit_count_reg + CW'(1);
                        event_next       = kclock_pkg::EV_DIGIT;
                    end
                end else if (s_key_index == kclock_pkg::KEY_CONFIRM) begin
                    digit_count_next = '0;
                    if (digit_count_reg == CW'(kclock_pkg::CODE_DIGITS) && code_match) begin
                        event_next       = kclock_pkg::EV_GRANTED;
                        drive_next       = kclock_pkg::DRIVE_OPEN;
                        wrong_count_next = '0;
                        mode_next        = kclock_pkg::MODE_GRANTED;
                    end else if (wrong_inc >= max_attempts_reg) begin
                        event_next       = kclock_pkg::EV_ALARM;
                        wrong_count_next = '0;
                    end else begin
                        event_next       = kclock_pkg::EV_WRONG;
                        wrong_count_next = wrong_inc;
                    end
                end else if (s_key_index == kclock_pkg::KEY_CLEAR) begin
                    event_next       = kclock_pkg::EV_CLEARED;
                    digit_count_next = '0;
                    wrong_count_next = '0;
                end else if (s_key_index == kclock_pkg::KEY_CLOSE) begin
                    event_next       = kclock_pkg::EV_CLOSED;
                    drive_next       = kclock_pkg::DRIVE_CLOSE;
                    digit_count_next = '0;
                    wrong_count_next = '0;
                end else if (s_key_index == kclock_pkg::KEY_MANUAL) begin
                    event_next = kclock_pkg::EV_MANUAL;
                    mode_next  = kclock_pkg::MODE_MANUAL;
                end
            end
        endcase
    end

    // Lock state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg <= '0;
            wrong_count_reg <= '0;
            mode_reg        <= kclock_pkg::MODE_ENTRY;
        end else if (accept) begin
            digit_count_reg <= digit_count_next;
            wrong_count_reg <= wrong_count_next;
            mode_reg        <= mode_next;
        end
    end

    // Entry buffer, no reset
    always_ff @(posedge aclk) begin
        if (accept && buf_we) begin
            digit_buf_reg[digit_count_reg[IW-1:0]] <= digit_value;
        end
    end

    // Output register
    assign m_valid_next = accept || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            event_reg    <= event_next;
            drive_reg    <= drive_next;
            digits_reg   <= digit_count_next[3:0];
            errors_reg   <= wrong_count_next;
            awaiting_reg <= (mode_next != kclock_pkg::MODE_ENTRY);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_event_code     = event_reg;
    assign m_door_drive     = drive_reg;
    assign m_digits_entered = digits_reg;
    assign m_error_count    = errors_reg;
    assign m_awaiting_close = awaiting_reg;

    // Checks
    `KCLOCK_ASSERT(a_count_bound, aclk, aresetn, digit_count_reg <= CW'(kclock_pkg::CODE_DIGITS), "digit count beyond buffer")
    `KCLOCK_ASSERT(a_await_mode, aclk, aresetn, !m_valid_reg || (awaiting_reg == (mode_reg != kclock_pkg::MODE_ENTRY)), "awaiting_close out of step with mode")
    `KCLOCK_ASSERT(a_grant_opens, aclk, aresetn, !m_valid_reg || (event_reg != kclock_pkg::EV_GRANTED) || (drive_reg == kclock_pkg::DRIVE_OPEN), "grant without open drive")
    `KCLOCK_ASSERT_NEXT(a_open_hold, aclk, aresetn, accept && (mode_reg == kclock_pkg::MODE_GRANTED || mode_reg == kclock_pkg::MODE_MANUAL) && (s_key_index != kclock_pkg::KEY_CLOSE), $stable(digit_count_reg) && $stable(wrong_count_reg) && $stable(mode_reg), "door-open mode changed on a non-close key")

endmodule

### design/kclock_match.sv
// ----------------------------------------------------------------------------
// Keypad combination lock code compare
// Compares every entered digit with its nibble of the code word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kclock_match (
    input  kclock_pkg::digit_buf_t digit_buf,
    input  logic [31:0]            code_word,
    output logic                   code_match
);

    logic [kclock_pkg::CODE_DIGITS-1:0] hit;

    // Digit j is held in nibble (CODE_DIGITS-1-j) mod 8 of the code word
    for (genvar j = 0; j < kclock_pkg::CODE_DIGITS; j++) begin : g_digit
        localparam int POS = (kclock_pkg::CODE_DIGITS - 1 - j) % 8;
        assign hit[j] = (digit_buf[j] == code_word[4*POS +: 4]);
    end

    assign code_match = &hit;

endmodule
